@@ rtl/hbpq_pkg.sv @@
// Shared types, constants, microcode program and compare helper for the
// binary heap priority queue. No dependencies.
`timescale 1ns / 1ps

package hbpq_pkg;

    // Heap geometry
    localparam int CAPACITY  = 31;
    localparam int IDX_W     = $clog2(CAPACITY + 1);
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int KEY_W     = 32;
    localparam int OCC_W     = 5;
    localparam int UPC_W     = 4;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Order codes
    localparam logic ORDER_MAX = 1'b0;
    localparam logic ORDER_MIN = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key;
    } hbpq_in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] top_key;
        logic [1:0]              status;
        logic [OCC_W-1:0]        occupancy;
    } hbpq_out_t;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_INS_START,
        ACT_RD_PARENT,
        ACT_UP,
        ACT_PLACE,
        ACT_RD_ENDS,
        ACT_REM_START,
        ACT_RD_KIDS,
        ACT_DOWN,
        ACT_FINISH
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_REMOVE,
        C_FULL,
        C_ROOT,
        C_UP_MOVE,
        C_EMPTY,
        C_LEAF,
        C_DN_MOVE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t             act;
        cond_t            cond;
        logic [UPC_W-1:0] tgt;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic remove;
        logic full;
        logic empty;
        logic root;
        logic leaf;
        logic up_move;
        logic dn_move;
    } hbpq_flags_t;

    // Step addresses
    localparam logic [UPC_W-1:0] UPC_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] UPC_INS_CHK  = 4'd2;
    localparam logic [UPC_W-1:0] UPC_INS_TEST = 4'd3;
    localparam logic [UPC_W-1:0] UPC_INS_CMP  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_INS_DONE = 4'd5;
    localparam logic [UPC_W-1:0] UPC_PLACE    = 4'd6;
    localparam logic [UPC_W-1:0] UPC_REM_CHK  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_REM_LOAD = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DN_TEST  = 4'd9;
    localparam logic [UPC_W-1:0] UPC_DN_CMP   = 4'd10;
    localparam logic [UPC_W-1:0] UPC_FINISH   = 4'd11;
    localparam logic [UPC_W-1:0] UPC_STALL    = 4'd12;

    // Microcode program: on a true condition jump to tgt, else step on
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_word_t w;
        case (upc)
            UPC_IDLE:     w = '{ACT_ACCEPT,    C_NO_IN,    UPC_IDLE};
            UPC_DISPATCH: w = '{ACT_NONE,      C_REMOVE,   UPC_REM_CHK};
            UPC_INS_CHK:  w = '{ACT_INS_START, C_FULL,     UPC_FINISH};
            UPC_INS_TEST: w = '{ACT_RD_PARENT, C_ROOT,     UPC_PLACE};
            UPC_INS_CMP:  w = '{ACT_UP,        C_UP_MOVE,  UPC_INS_TEST};
            UPC_INS_DONE: w = '{ACT_NONE,      C_ALWAYS,   UPC_FINISH};
            UPC_PLACE:    w = '{ACT_PLACE,     C_ALWAYS,   UPC_FINISH};
            UPC_REM_CHK:  w = '{ACT_RD_ENDS,   C_EMPTY,    UPC_FINISH};
            UPC_REM_LOAD: w = '{ACT_REM_START, C_NEVER,    UPC_IDLE};
            UPC_DN_TEST:  w = '{ACT_RD_KIDS,   C_LEAF,     UPC_PLACE};
            UPC_DN_CMP:   w = '{ACT_DOWN,      C_DN_MOVE,  UPC_DN_TEST};
            UPC_FINISH:   w = '{ACT_FINISH,    C_OUT_FREE, UPC_IDLE};
            UPC_STALL:    w = '{ACT_NONE,      C_ALWAYS,   UPC_FINISH};
            default:      w = '{ACT_NONE,      C_ALWAYS,   UPC_IDLE};
        endcase
        return w;
    endfunction

    // True when key a belongs above key b under the selected order
    function automatic logic better(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b,
                                    input logic                    order);
        logic res;
        if (order == ORDER_MIN) begin
            res = (a < b);
        end else begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

@@ rtl/hbpq_seq.sv @@
// Microcode sequencer: step counter, program ROM and jump condition select.
// Depends on hbpq_pkg.
`timescale 1ns / 1ps

module hbpq_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hbpq_pkg::hbpq_flags_t flags,
    input  logic                 in_valid,
    input  logic                 out_free,
    output hbpq_pkg::ctrl_word_t ctrl
);
    import hbpq_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ctrl_word_t       word;
    logic             hit;

    assign word = ucode_rom(upc_reg);
    assign ctrl = word;

    // Condition select
    always_comb begin
        case (word.cond)
            C_NEVER:    hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_NO_IN:    hit = !in_valid;
            C_REMOVE:   hit = flags.remove;
            C_FULL:     hit = flags.full;
            C_ROOT:     hit = flags.root;
            C_UP_MOVE:  hit = flags.up_move;
            C_EMPTY:    hit = flags.empty;
            C_LEAF:     hit = flags.leaf;
            C_DN_MOVE:  hit = flags.dn_move;
            C_OUT_FREE: hit = out_free;
            default:    hit = 1'b1;
        endcase
    end

    assign upc_next = hit ? word.tgt : upc_reg + UPC_W'(1);

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ rtl/hbpq_dp.sv @@
// Heap datapath: key store, registered reads, count, index and key registers.
// Depends on hbpq_pkg; driven by the control word from hbpq_seq.
`timescale 1ns / 1ps

module hbpq_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hbpq_pkg::ctrl_word_t  ctrl,
    input  logic                  order,
    input  logic                  in_valid,
    input  hbpq_pkg::hbpq_in_t    in_data,
    output hbpq_pkg::hbpq_flags_t flags,
    output hbpq_pkg::hbpq_out_t   result
);
    import hbpq_pkg::*;

    // Key store, entries 1..CAPACITY used
    logic signed [KEY_W-1:0] mem [0:MEM_DEPTH-1];

    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [KEY_W-1:0] cur_reg, cur_next;
    logic signed [KEY_W-1:0] top_reg, top_next;
    logic [1:0]              status_reg, status_next;
    logic                    req_reg, req_next;
    logic signed [KEY_W-1:0] rd0_reg, rd1_reg;

    logic [IDX_W-1:0]        raddr0, raddr1;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    logic [IDX_W:0]          left_w, right_w;
    logic                    sib_ok, pick_right;
    logic signed [KEY_W-1:0] child_key;
    logic [IDX_W-1:0]        child_idx;
    logic                    full, empty, up_move, dn_move;

    // Child and compare logic
    assign left_w     = {idx_reg, 1'b0};
    assign right_w    = {idx_reg, 1'b1};
    assign sib_ok     = (right_w <= {1'b0, cnt_reg});
    assign pick_right = sib_ok && better(rd1_reg, rd0_reg, order);
    assign child_key  = pick_right ? rd1_reg : rd0_reg;
    assign child_idx  = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
    assign up_move    = better(cur_reg, rd0_reg, order);
    assign dn_move    = better(child_key, cur_reg, order);
    assign full       = (cnt_reg >= IDX_W'(CAPACITY));
    assign empty      = (cnt_reg == '0);

    assign flags.remove  = req_reg;
    assign flags.full    = full;
    assign flags.empty   = empty;
    assign flags.root    = (idx_reg == IDX_W'(1));
    assign flags.leaf    = (left_w > {1'b0, cnt_reg});
    assign flags.up_move = up_move;
    assign flags.dn_move = dn_move;

    assign result.top_key   = top_reg;
    assign result.status    = status_reg;
    assign result.occupancy = OCC_W'(cnt_reg);

    // Action decode
    always_comb begin
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        top_next    = top_reg;
        status_next = status_reg;
        req_next    = req_reg;
        raddr0      = '0;
        raddr1      = '0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = cur_reg;
        case (ctrl.act)
            ACT_ACCEPT: begin
                if (in_valid) begin
                    req_next    = in_data.req_type;
                    cur_next    = in_data.key;
                    top_next    = '0;
                    status_next = STATUS_DONE;
                end
            end
            ACT_INS_START: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                    idx_next = cnt_reg + IDX_W'(1);
                end
            end
            ACT_RD_PARENT: begin
                raddr0 = idx_reg >> 1;
            end
            ACT_UP: begin
                // parent moves down into the hole, or the key settles here
                wr_en   = 1'b1;
                wr_data = up_move ? rd0_reg : cur_reg;
                if (up_move) begin
                    idx_next = idx_reg >> 1;
                end
            end
            ACT_PLACE: begin
                wr_en = 1'b1;
            end
            ACT_RD_ENDS: begin
                raddr0 = IDX_W'(1);
                raddr1 = cnt_reg;
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end
            end
            ACT_REM_START: begin
                top_next = rd0_reg;
                cur_next = rd1_reg;
                cnt_next = cnt_reg - IDX_W'(1);
                idx_next = IDX_W'(1);
            end
            ACT_RD_KIDS: begin
                raddr0 = left_w[IDX_W-1:0];
                raddr1 = right_w[IDX_W-1:0];
            end
            ACT_DOWN: begin
                // better child moves up into the hole, or the key settles here
                wr_en   = 1'b1;
                wr_data = dn_move ? child_key : cur_reg;
                if (dn_move) begin
                    idx_next = child_idx;
                end
            end
            default: begin
            end
        endcase
    end

    // Key store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        top_reg    <= top_next;
        status_reg <= status_next;
        req_reg    <= req_next;
    end

endmodule

@@ rtl/binary_heap_priority_queue.sv @@
// Binary heap priority queue, 31 signed 32-bit keys, one result per request.
// Insert sifts the new key up from the next free slot and remove sifts the last key
// down from the root, a read step and a compare step per level; a refused request
// skips both. The next request is taken the cycle after the result loads.
// Synchronous active-low reset empties the heap and selects max order.
// Depends on hbpq_pkg, hbpq_seq, hbpq_dp.
`timescale 1ns / 1ps

module binary_heap_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hbpq_pkg::hbpq_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hbpq_pkg::hbpq_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import hbpq_pkg::*;

    ctrl_word_t  ctrl;
    hbpq_flags_t flags;
    hbpq_out_t   result;
    logic        out_free;
    logic        finish;

    logic        order_reg, order_next;
    logic        m_valid_reg, m_valid_next;
    hbpq_out_t   m_data_reg, m_data_next;

    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (ctrl.act == ACT_FINISH) && out_free;
    assign s_ready   = (ctrl.act == ACT_ACCEPT);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    hbpq_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flags    (flags),
        .in_valid (s_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    hbpq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .order    (order_reg),
        .in_valid (s_valid),
        .in_data  (s_data),
        .flags    (flags),
        .result   (result)
    );

    // Order register and output stage next values
    always_comb begin
        order_next   = (cfg_valid && cfg_ready) ? cfg_data : order_reg;
        m_valid_next = finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = finish ? result : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg   <= ORDER_MAX;
            m_valid_reg <= 1'b0;
        end else begin
            order_reg   <= order_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

@@ test/binary_heap_priority_queue_test.sv @@
// Self-checking testbench for binary_heap_priority_queue: drives insert/remove
// requests and order changes, predicts every result with its own heap model.
// Depends on hbpq_pkg and the binary_heap_priority_queue RTL.
`timescale 1ns / 1ps

module binary_heap_priority_queue_test;
    import hbpq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;
    localparam int HOLD_CYCLES    = 400;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    hbpq_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    hbpq_out_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    // Predictor state: heap copy, entry count and selected order
    logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
    int                      heap_count;
    logic                    heap_order;

    hbpq_out_t expected_results [$];
    int        mismatch_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_request;

    binary_heap_priority_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // True when key a sits closer to the root than key b under the current order
    function automatic logic key_above(input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
        if (heap_order == ORDER_MIN) begin
            return a < b;
        end
        return a > b;
    endfunction

    // Apply one request to the heap copy and return the result it must produce
    function automatic hbpq_out_t heap_predict(input hbpq_in_t item);
        hbpq_out_t               res;
        int                      i;
        int                      c;
        logic signed [KEY_W-1:0] tmp;
        res = '0;
        res.status = STATUS_DONE;
        if (item.req_type == REQ_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_count++;
                heap_keys[heap_count] = item.key;
                i = heap_count;
                // sift up while strictly better than the parent
                while (i > 1 && key_above(heap_keys[i], heap_keys[i / 2])) begin
                    tmp = heap_keys[i];
                    heap_keys[i] = heap_keys[i / 2];
                    heap_keys[i / 2] = tmp;
                    i = i / 2;
                end
            end
        end else begin
            if (heap_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.top_key = heap_keys[1];
                heap_keys[1] = heap_keys[heap_count];
                heap_count--;
                i = 1;
                // sift down: better child, left on a tie, swap while strictly better
                while (2 * i <= heap_count) begin
                    c = 2 * i;
                    if (c + 1 <= heap_count && key_above(heap_keys[c + 1], heap_keys[c])) begin
                        c = c + 1;
                    end
                    if (!key_above(heap_keys[c], heap_keys[i])) begin
                        break;
                    end
                    tmp = heap_keys[i];
                    heap_keys[i] = heap_keys[c];
                    heap_keys[c] = tmp;
                    i = c;
                end
            end
        end
        res.occupancy = OCC_W'(heap_count);
        return res;
    endfunction

    // Keys: small range for ties, values near both extremes, full random
    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(3))
            0: return KEY_W'($urandom_range(8) - 4);
            1: begin
                if ($urandom_range(1) != 0) begin
                    return 32'h7fff_fff0 + KEY_W'($urandom_range(15));
                end
                return 32'h8000_0000 + KEY_W'($urandom_range(15));
            end
            default: return KEY_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offer one request; valid stays up after the transfer unless a gap follows
    task automatic send_request(input logic req, input logic signed [KEY_W-1:0] key);
        hbpq_in_t item;
        int       gap;
        item.req_type = req;
        item.key = key;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 16);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(heap_predict(item));
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Order register write, only with the block idle
    task automatic write_order(input logic order);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= order;
        do @(posedge aclk); while (!cfg_ready);
        heap_order = order;
        cfg_valid <= 1'b0;
    endtask

    // Remove on empty, then extreme and tied keys in and back out
    task automatic test_extremes(input logic order);
        logic signed [KEY_W-1:0] keys [8];
        keys = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh1,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh5555_aaaa};
        write_order(order);
        send_request(REQ_REMOVE, 32'sh0);
        foreach (keys[k]) send_request(REQ_INSERT, keys[k]);
        repeat (9) send_request(REQ_REMOVE, $urandom());
    endtask

    // Order flipped while keys are held
    task automatic test_order_switch();
        write_order(ORDER_MAX);
        repeat (8) send_request(REQ_INSERT, rand_key());
        write_order(ORDER_MIN);
        repeat (4) send_request(REQ_REMOVE, 32'sh0);
        repeat (3) send_request(REQ_INSERT, rand_key());
        write_order(ORDER_MAX);
        repeat (8) send_request(REQ_REMOVE, 32'sh0);
    endtask

    // Fill past capacity, then drain past empty
    task automatic test_fill_and_drain(input logic order);
        write_order(order);
        repeat (CAPACITY + 2) send_request(REQ_INSERT, rand_key());
        repeat (CAPACITY + 2) send_request(REQ_REMOVE, rand_key());
    endtask

    task automatic test_random_mix(input logic order, input int count, input int insert_pct);
        write_order(order);
        repeat (count) begin
            if ($urandom_range(99) < insert_pct) begin
                send_request(REQ_INSERT, rand_key());
            end else begin
                send_request(REQ_REMOVE, rand_key());
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_back_pressure();
        int saved_tx;
        saved_tx = tx_idle_pct;
        write_order(ORDER_MIN);
        tx_idle_pct = 0;
        rx_hold_request = HOLD_CYCLES;
        repeat (20) send_request(REQ_INSERT, rand_key());
        repeat (20) send_request(REQ_REMOVE, rand_key());
        tx_idle_pct = saved_tx;
    endtask

    // Back to back transfers with no idling on either side
    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix(ORDER_MAX, 200, 60);
        tx_idle_pct = 33;
        rx_idle_pct = 33;
    endtask

    // Receiver: random ready, or a counted hold-off when one is requested
    initial begin : receiver
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request != 0) begin
                hold = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold != 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        hbpq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: top %0d status %0d occ %0d",
                                          m_data.top_key, m_data.status, m_data.occupancy));
            end else begin
                want = expected_results.pop_front();
                if (m_data.top_key !== want.top_key) begin
                    report_mismatch($sformatf("top_key got %0d expected %0d",
                                              m_data.top_key, want.top_key));
                end
                if (m_data.status !== want.status) begin
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              m_data.status, want.status));
                end
                if (m_data.occupancy !== want.occupancy) begin
                    report_mismatch($sformatf("occupancy got %0d expected %0d",
                                              m_data.occupancy, want.occupancy));
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        heap_count = 0;
        heap_order = ORDER_MAX;
        mismatch_count = 0;
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        rx_hold_request = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes(ORDER_MAX);
        test_extremes(ORDER_MIN);
        test_order_switch();
        test_fill_and_drain(ORDER_MAX);
        test_fill_and_drain(ORDER_MIN);
        test_random_mix(ORDER_MAX, 350, 55);
        test_random_mix(ORDER_MIN, 350, 50);
        test_back_pressure();
        test_no_idle();
        test_random_mix(ORDER_MIN, 150, 70);
        test_random_mix(ORDER_MAX, 120, 35);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
